// ===== hw/rtl/opi_pkg.sv =====
// Shared types, constants and the arctangent table for the pose integrator.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package opi_pkg;

	localparam int CORDIC_STEPS   = 16;
	localparam int POSITION_WIDTH = 32;
	localparam int TABLE_LEN      = 24;
	localparam int NSTEPS         = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int STEP_W         = $clog2(TABLE_LEN);

	// rotation vector in units of 2^-48 m; magnitude stays below 2^56
	localparam int VEC_W = 58;
	localparam int DX_W  = VEC_W - 32;
	localparam int SUM_W = ((POSITION_WIDTH > 32) ? POSITION_WIDTH : 32) + 1;

	localparam logic signed [32:0] GAIN_S = 33'sh09B74EDA8;

	localparam logic signed [SUM_W-1:0] POS_MAX =
		SUM_W'((64'sd1 <<< (POSITION_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] POS_MIN =
		SUM_W'(-(64'sd1 <<< (POSITION_WIDTH - 1)));

	// arctangent of 2^-i in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURN [0:TABLE_LEN-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	typedef enum logic {
		CMD_STEP = 1'b0,
		CMD_LOAD = 1'b1
	} cmd_t;

	typedef struct packed {
		logic               command;
		logic signed [23:0] dist_delta;
		logic signed [15:0] heading_delta;
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [15:0] pose_heading;
	} odo_item_t;

	typedef struct packed {
		logic signed [31:0] x_out;
		logic signed [31:0] y_out;
		logic signed [15:0] heading_out;
		logic               saturated;
	} pose_item_t;

	// fields that ride along the rotation chain untouched
	typedef struct packed {
		cmd_t               command;
		logic signed [15:0] heading;
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
	} side_t;

	typedef struct packed {
		side_t                    side;
		logic signed [VEC_W-1:0]  vx;
		logic signed [VEC_W-1:0]  vy;
		logic signed [31:0]       z;
	} cell_t;

endpackage

`default_nettype wire

// ===== hw/rtl/opi_prep.sv =====
// Front end: heading state, mid-step angle with quadrant fold, gain multiply.
// Depends on opi_pkg.
`default_nettype none

module opi_prep (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire opi_pkg::odo_item_t in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output opi_pkg::cell_t          out_data
);
	import opi_pkg::*;

	logic               valid_s1, valid_s2;
	logic               ready_s1, ready_s2;
	logic signed [15:0] heading_q;
	side_t              side_s1, side_s2;
	logic signed [24:0] dist_s1;
	logic signed [31:0] z_s1, z_s2;
	logic signed [VEC_W-1:0] vx_s2;

	logic [16:0]        mid_sum;
	logic               fold;
	logic signed [15:0] heading_nxt;
	logic signed [24:0] dist_ext;
	logic               take;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign take     = in_valid && ready_s1;

	always_comb begin
		// 2*heading + delta, units 2^-17 turn
		mid_sum  = {heading_q, 1'b0} + {in_item.heading_delta[15], in_item.heading_delta};
		fold     = mid_sum[16] ^ mid_sum[15];
		dist_ext = {in_item.dist_delta[23], in_item.dist_delta};
		if (in_item.command == CMD_LOAD) begin
			heading_nxt = in_item.pose_heading;
		end else begin
			heading_nxt = heading_q + in_item.heading_delta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			heading_q <= '0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (take) heading_q <= heading_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			side_s1.command <= cmd_t'(in_item.command);
			side_s1.heading <= heading_nxt;
			side_s1.pose_x  <= in_item.pose_x;
			side_s1.pose_y  <= in_item.pose_y;
			dist_s1         <= fold ? -dist_ext : dist_ext;
			z_s1            <= $signed({mid_sum[16] ^ fold, mid_sum[15:0], 15'b0});
		end
		if (valid_s1 && ready_s2) begin
			side_s2 <= side_s1;
			vx_s2   <= dist_s1 * GAIN_S;
			z_s2    <= z_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign out_data.side = side_s2;
	assign out_data.vx   = vx_s2;
	assign out_data.vy   = '0;
	assign out_data.z    = z_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/opi_cell.sv =====
// One CORDIC rotation step with a registered output and its own valid bit.
// Depends on opi_pkg for the vector type and the arctangent table.
`default_nettype none

module opi_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [opi_pkg::STEP_W-1:0] step,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire opi_pkg::cell_t            in_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output opi_pkg::cell_t                 out_data
);
	import opi_pkg::*;

	logic                    valid_s1;
	cell_t                   data_s1;
	cell_t                   nxt;
	logic signed [VEC_W-1:0] sx, sy;
	logic signed [31:0]      angle;

	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		sx    = in_data.vx >>> step;
		sy    = in_data.vy >>> step;
		angle = $signed(ATAN_TURN[step]);
		nxt   = in_data;
		// rotate toward zero residual angle
		if (!in_data.z[31]) begin
			nxt.vx = in_data.vx - sy;
			nxt.vy = in_data.vy + sx;
			nxt.z  = in_data.z - angle;
		end else begin
			nxt.vx = in_data.vx + sy;
			nxt.vy = in_data.vy - sx;
			nxt.z  = in_data.z + angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) data_s1 <= nxt;
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

`default_nettype wire

// ===== hw/rtl/opi_accum.sv =====
// Back end: rounds the rotated vector, holds x and y, saturates, drives results.
// Depends on opi_pkg.
`default_nettype none

module opi_accum (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire opi_pkg::cell_t      in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output opi_pkg::pose_item_t      out_item
);
	import opi_pkg::*;

	localparam int PW = POSITION_WIDTH;

	logic                    valid_s1, out_valid_q, ready_o;
	side_t                   side_s1;
	logic signed [DX_W-1:0]  dx_s1, dy_s1;
	logic signed [VEC_W-1:0] rx, ry;
	logic signed [PW-1:0]    x_q, y_q;
	pose_item_t              out_q;

	logic signed [SUM_W-1:0] x_raw, y_raw, x_clip, y_clip;
	logic                    x_sat, y_sat;
	logic                    load;

	assign ready_o  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || ready_o;
	assign load     = valid_s1 && ready_o;

	// round to 2^-16 m: add half an LSB, floor shift by 32
	assign rx = in_data.vx + VEC_W'(64'sh80000000);
	assign ry = in_data.vy + VEC_W'(64'sh80000000);

	always_comb begin
		if (side_s1.command == CMD_LOAD) begin
			x_raw = SUM_W'(side_s1.pose_x);
			y_raw = SUM_W'(side_s1.pose_y);
		end else begin
			x_raw = SUM_W'(x_q) + SUM_W'(dx_s1);
			y_raw = SUM_W'(y_q) + SUM_W'(dy_s1);
		end
		x_sat  = (x_raw > POS_MAX) || (x_raw < POS_MIN);
		y_sat  = (y_raw > POS_MAX) || (y_raw < POS_MIN);
		x_clip = (x_raw > POS_MAX) ? POS_MAX : ((x_raw < POS_MIN) ? POS_MIN : x_raw);
		y_clip = (y_raw > POS_MAX) ? POS_MAX : ((y_raw < POS_MIN) ? POS_MIN : y_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			x_q         <= '0;
			y_q         <= '0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (ready_o) out_valid_q <= valid_s1;
			if (load) begin
				x_q <= x_clip[PW-1:0];
				y_q <= y_clip[PW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			side_s1 <= in_data.side;
			dx_s1   <= rx[VEC_W-1:32];
			dy_s1   <= ry[VEC_W-1:32];
		end
		if (load) begin
			out_q.x_out       <= x_clip[31:0];
			out_q.y_out       <= y_clip[31:0];
			out_q.heading_out <= side_s1.heading;
			out_q.saturated   <= x_sat || y_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/odometry_pose_integrator_unit.sv =====
// An item passes the front-end registers, the rotation cells and the back-end registers.
// Throughput: one item per cycle while results are taken; every stage has its own
// valid bit, so a stalled result only blocks input once every stage has filled.
// The heading add at the front and the x/y saturating add at the back are the
// only state feedback, each a single add per cycle.
// Reset clears x, y and heading to zero and empties the pipeline.
`default_nettype none

module odometry_pose_integrator_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                odo_valid,
	output logic                     odo_ready,
	input  wire opi_pkg::odo_item_t  odo,
	output logic                     pose_valid,
	input  wire logic                pose_ready,
	output opi_pkg::pose_item_t      pose
);
	import opi_pkg::*;

	localparam int DEPTH = NSTEPS + 4;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cell_t             link [0:NSTEPS];
	logic [NSTEPS:0]   link_valid;
	logic [NSTEPS:0]   link_ready;
	logic [CNT_W-1:0]  inflight_q;

	opi_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (odo_valid),
		.in_ready  (odo_ready),
		.in_item   (odo),
		.out_valid (link_valid[0]),
		.out_ready (link_ready[0]),
		.out_data  (link[0])
	);

	for (genvar k = 0; k < NSTEPS; k++) begin : g_cell
		opi_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (STEP_W'(k)),
			.in_valid  (link_valid[k]),
			.in_ready  (link_ready[k]),
			.in_data   (link[k]),
			.out_valid (link_valid[k+1]),
			.out_ready (link_ready[k+1]),
			.out_data  (link[k+1])
		);
	end

	opi_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (link_valid[NSTEPS]),
		.in_ready  (link_ready[NSTEPS]),
		.in_data   (link[NSTEPS]),
		.out_valid (pose_valid),
		.out_ready (pose_ready),
		.out_item  (pose)
	);

	// count items between input and output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({odo_valid && odo_ready, pose_valid && pose_ready})
				2'b10:   inflight_q <= inflight_q + CNT_W'(1);
				2'b01:   inflight_q <= inflight_q - CNT_W'(1);
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(DEPTH))
		else $error("more items in flight than pipeline stages");

	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid |-> inflight_q != '0)
		else $error("result shown with no item in flight");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!odo_ready |-> pose_valid && !pose_ready && inflight_q == CNT_W'(DEPTH))
		else $error("input stalled while the pipeline has room");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid && pose.saturated |->
			pose.x_out == POS_MAX[31:0] || pose.x_out == POS_MIN[31:0] ||
			pose.y_out == POS_MAX[31:0] || pose.y_out == POS_MIN[31:0])
		else $error("saturated flag without a clipped coordinate");

endmodule

`default_nettype wire
